// ----- src/gnp_pkg.sv -----
// shared types and constants for the grid neighbour peeling block
// no dependencies; used by every module under src
`default_nettype none
package gnp_pkg;

    localparam int COORD_W   = 13;
    localparam int COUNT_W   = 17;
    localparam int THR_W     = 4;
    localparam int NCNT_W    = 4;
    localparam int NB_W      = 4;
    localparam int NB_LAST   = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [THR_W-1:0] THR_RESET = 4'd4;

    typedef struct packed {
        logic occupied;
        logic end_of_row;
        logic end_of_grid;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cleared_count;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic               do_write;
        logic               data;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] fill_from;
        logic [COORD_W-1:0] fill_to;
        logic               do_peel;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic               overflow;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FILL,
        B_RD,
        B_ACC,
        B_RESULT
    } back_state_t;

    // neighbour offsets: 2'b01 is +1, 2'b11 is -1, 2'b00 is none
    function automatic logic [1:0] nb_dx(input logic [NB_W-1:0] k);
        logic [1:0] r;
        unique case (k)
            4'd1: r = 2'b01;
            4'd2: r = 2'b11;
            4'd5: r = 2'b01;
            4'd6: r = 2'b11;
            4'd7: r = 2'b11;
            4'd8: r = 2'b01;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nb_dy(input logic [NB_W-1:0] k);
        logic [1:0] r;
        unique case (k)
            4'd3: r = 2'b01;
            4'd4: r = 2'b11;
            4'd5: r = 2'b01;
            4'd6: r = 2'b01;
            4'd7: r = 2'b11;
            4'd8: r = 2'b11;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/gnp_front.sv -----
// front part: tracks row and column of incoming cells and turns each
// transfer into one command for the back part; uses gnp_pkg
`default_nettype none
module gnp_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gnp_pkg::item_t item,
    input  wire logic          take,
    output gnp_pkg::cmd_t      cmd
);
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int RW1 = $clog2(MAX_HEIGHT + 1);

    logic [CW1-1:0] col_reg, col_next, width_reg, width_next, width_new;
    logic [RW1-1:0] row_reg, row_next;
    logic           ovf_reg, ovf_next;
    logic [CW1:0]   col_inc;
    logic           row_ovf, col_ovf, row_end;

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + (CW1+1)'(1);
        row_ovf   = row_reg >= RW1'(MAX_HEIGHT);
        col_ovf   = col_reg >= CW1'(MAX_WIDTH);
        row_end   = item.end_of_row | item.end_of_grid;
        ovf_next  = ovf_reg | row_ovf | col_ovf;
        col_next  = col_ovf ? col_reg : col_inc[CW1-1:0];
        width_new = width_reg;
        if (width_reg == '0)
            width_new = (col_inc < (CW1+1)'(MAX_WIDTH)) ? col_inc[CW1-1:0] : CW1'(MAX_WIDTH);
        width_next = width_reg;
        row_next   = row_reg;

        cmd           = '0;
        cmd.do_write  = !(row_ovf || col_ovf) && (width_reg == '0 || col_reg < width_reg);
        cmd.data      = item.occupied;
        cmd.row       = gnp_pkg::COORD_W'(row_reg);
        cmd.col       = gnp_pkg::COORD_W'(col_reg);
        cmd.fill_from = gnp_pkg::COORD_W'(width_new);
        cmd.fill_to   = gnp_pkg::COORD_W'(width_new);
        if (row_end)
        begin
            width_next = width_new;
            col_next   = '0;
            if (!row_ovf)
            begin
                cmd.fill_from = gnp_pkg::COORD_W'(col_inc);
                row_next      = row_reg + RW1'(1);
            end
        end
        cmd.do_peel  = item.end_of_grid;
        cmd.width    = gnp_pkg::COORD_W'(width_new);
        cmd.height   = gnp_pkg::COORD_W'(row_next);
        cmd.overflow = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            width_reg <= '0;
            row_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (item.end_of_grid)
            begin
                col_reg   <= '0;
                width_reg <= '0;
                row_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                col_reg   <= col_next;
                width_reg <= width_next;
                row_reg   <= row_next;
                ovf_reg   <= ovf_next;
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/gnp_queue.sv -----
// two-entry command queue between front and back parts
// uses gnp_pkg::cmd_t
`default_nettype none
module gnp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire gnp_pkg::cmd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output gnp_pkg::cmd_t      rdata,
    output logic               empty
);
    gnp_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/gnp_back.sv -----
// back part: owns the cell store, executes writes and row fills, runs the
// peeling sweeps and holds the result register; uses gnp_pkg
`default_nettype none
module gnp_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gnp_pkg::cmd_t              cmd,
    input  wire logic                       cmd_empty,
    output logic                            cmd_pop,
    input  wire logic [gnp_pkg::THR_W-1:0]  threshold,
    output gnp_pkg::result_t                result,
    output logic                            empty,
    input  wire logic                       pop
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int RW1 = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = CW + RW;

    logic mem [2**AW];
    logic rdata_reg;

    gnp_pkg::back_state_t state_reg, state_next;
    logic [CW1-1:0] x_reg, x_next, w_reg, w_next, fx_reg, fx_next, fto_reg, fto_next;
    logic [RW1-1:0] y_reg, y_next, h_reg, h_next;
    logic [RW-1:0]  frow_reg, frow_next;
    logic [gnp_pkg::NB_W-1:0]    k_reg, k_next;
    logic [gnp_pkg::NCNT_W-1:0]  n_reg, n_next, n_sum;
    logic [gnp_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic changed_reg, changed_next, ovf_reg, ovf_next, inb_reg, inb_next;
    logic peel_reg, peel_next, out_valid_reg, out_valid_next;
    gnp_pkg::result_t out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [1:0]    dx, dy;
    logic [CW1-1:0] nx;
    logic [RW1-1:0] ny;
    logic           last_x, last_y;

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= 1'b0 | (state_reg == gnp_pkg::B_IDLE && cmd.data);
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        dx     = gnp_pkg::nb_dx(k_reg);
        dy     = gnp_pkg::nb_dy(k_reg);
        nx     = (dx == 2'b01) ? x_reg + CW1'(1) : (dx == 2'b11) ? x_reg - CW1'(1) : x_reg;
        ny     = (dy == 2'b01) ? y_reg + RW1'(1) : (dy == 2'b11) ? y_reg - RW1'(1) : y_reg;
        last_x = (x_reg + CW1'(1)) >= w_reg;
        last_y = (y_reg + RW1'(1)) >= h_reg;
        inb_next = !((dx == 2'b11 && x_reg == '0) || (dx == 2'b01 && last_x) ||
                     (dy == 2'b11 && y_reg == '0) || (dy == 2'b01 && last_y));
        raddr  = {ny[RW-1:0], nx[CW-1:0]};
        n_sum  = n_reg + gnp_pkg::NCNT_W'(inb_reg & rdata_reg);

        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        fx_next        = fx_reg;
        fto_next       = fto_reg;
        frow_next      = frow_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        changed_next   = changed_reg;
        ovf_next       = ovf_reg;
        peel_next      = peel_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        we             = 1'b0;
        waddr          = {y_reg[RW-1:0], x_reg[CW-1:0]};

        unique case (state_reg)
            gnp_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    we        = cmd.do_write;
                    waddr     = {cmd.row[RW-1:0], cmd.col[CW-1:0]};
                    frow_next = cmd.row[RW-1:0];
                    fx_next   = CW1'(cmd.fill_from);
                    fto_next  = CW1'(cmd.fill_to);
                    peel_next = cmd.do_peel;
                    w_next    = CW1'(cmd.width);
                    h_next    = RW1'(cmd.height);
                    ovf_next  = cmd.overflow;
                    x_next       = '0;
                    y_next       = '0;
                    k_next       = '0;
                    cnt_next     = '0;
                    changed_next = 1'b0;
                    if (cmd.fill_from < cmd.fill_to)
                        state_next = gnp_pkg::B_FILL;
                    else if (cmd.do_peel)
                        state_next = (cmd.width == '0 || cmd.height == '0) ?
                                     gnp_pkg::B_RESULT : gnp_pkg::B_RD;
                end
            end
            gnp_pkg::B_FILL:
            begin
                we      = 1'b1;
                waddr   = {frow_reg, fx_reg[CW-1:0]};
                fx_next = fx_reg + CW1'(1);
                if ((fx_reg + CW1'(1)) >= fto_reg)
                begin
                    if (!peel_reg)
                        state_next = gnp_pkg::B_IDLE;
                    else
                        state_next = (w_reg == '0 || h_reg == '0) ?
                                     gnp_pkg::B_RESULT : gnp_pkg::B_RD;
                end
            end
            gnp_pkg::B_RD:
            begin
                state_next = gnp_pkg::B_ACC;
            end
            gnp_pkg::B_ACC:
            begin
                state_next = gnp_pkg::B_RD;
                if (k_reg != '0 && k_reg != gnp_pkg::NB_W'(gnp_pkg::NB_LAST))
                begin
                    n_next = n_sum;
                    k_next = k_reg + gnp_pkg::NB_W'(1);
                end
                else if (k_reg == '0 && rdata_reg)
                begin
                    n_next = '0;
                    k_next = gnp_pkg::NB_W'(1);
                end
                else
                begin
                    if (k_reg != '0 && n_sum < threshold)
                    begin
                        we           = 1'b1;
                        changed_next = 1'b1;
                        if (cnt_reg != gnp_pkg::COUNT_MAX)
                            cnt_next = cnt_reg + gnp_pkg::COUNT_W'(1);
                    end
                    k_next = '0;
                    if (!last_x)
                        x_next = x_reg + CW1'(1);
                    else
                    begin
                        x_next = '0;
                        if (!last_y)
                            y_next = y_reg + RW1'(1);
                        else
                        begin
                            y_next = '0;
                            // a pass with a clear starts another pass
                            if (changed_next)
                                changed_next = 1'b0;
                            else
                                state_next = gnp_pkg::B_RESULT;
                        end
                    end
                end
            end
            gnp_pkg::B_RESULT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next         = 1'b1;
                    out_next.cleared_count = cnt_reg;
                    out_next.overflow      = ovf_reg;
                    state_next             = gnp_pkg::B_IDLE;
                end
            end
            default: state_next = gnp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gnp_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        fx_reg      <= fx_next;
        fto_reg     <= fto_next;
        frow_reg    <= frow_next;
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        changed_reg <= changed_next;
        ovf_reg     <= ovf_next;
        inb_reg     <= inb_next;
        peel_reg    <= peel_next;
        out_reg     <= out_next;
    end

    a_acc_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gnp_pkg::B_ACC |-> $past(state_reg) == gnp_pkg::B_RD)
        else $error("accumulate without a read");
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == gnp_pkg::B_RESULT)
        else $error("result without a finished sweep");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= gnp_pkg::NB_W'(gnp_pkg::NB_LAST))
        else $error("neighbour index out of range");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gnp_pkg::B_FILL |-> fx_reg < fto_reg)
        else $error("fill past row width");
endmodule
`default_nettype wire

// ----- src/grid_neighbour_peeling_top.sv -----
// top level of the grid neighbour peeling block
// depends on gnp_pkg, gnp_front, gnp_queue, gnp_back
//
// usage: cells come in row-major order on item with push/full; a cell
// transfer happens when push is high and full is low. the first end_of_row
// fixes the grid width, end_of_grid closes the grid and starts the sweeps.
// one result per grid appears on result while empty is low and is taken
// with pop. cfg_we/cfg_data write the 4-bit neighbour threshold (reset 4).
// loading: one cell per cycle while full is low, via a two-entry command
// queue; the store writer fills the missing cells of a short row.
// peeling: each cell is read from the store; an occupied one is followed
// by one store read per neighbour; passes repeat until one clears nothing,
// so latency is data dependent. cells of the next grid queue up and wait
// while a sweep runs.
// reset clears states and pointers, not the store or the sweep registers.
// if the result is not popped, the next grid still loads and sweeps; its
// result then waits in the back part and the queue fills, raising full.
`default_nettype none
module grid_neighbour_peeling_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gnp_pkg::item_t             item,
    input  wire logic                       push,
    output logic                            full,
    output gnp_pkg::result_t                result,
    output logic                            empty,
    input  wire logic                       pop,
    input  wire logic                       cfg_we,
    input  wire logic [gnp_pkg::THR_W-1:0]  cfg_data
);
    logic [gnp_pkg::THR_W-1:0] thr_reg;
    gnp_pkg::cmd_t front_cmd, q_cmd;
    logic take, q_empty, q_pop;

    assign take = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= gnp_pkg::THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    gnp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .item(item), .take(take), .cmd(front_cmd)
    );

    gnp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take), .wdata(front_cmd), .full(full),
        .pop(q_pop), .rdata(q_cmd), .empty(q_empty)
    );

    gnp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_empty(q_empty), .cmd_pop(q_pop),
        .threshold(thr_reg), .result(result), .empty(empty), .pop(pop)
    );
endmodule
`default_nettype wire
